// ----- rtl/lrpf_pkg.sv -----
// Shared types and constants of the line rasterizer with a paged framebuffer.
// Used by lrpf_ctrl, lrpf_dpath and line_rasterizer_page_framebuffer_core.
package lrpf_pkg;

    // Field widths of the item ports.
    localparam int MODE_W  = 2;
    localparam int COORD_W = 10;
    localparam int ADDR_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 12;

    // Pixels stacked in one framebuffer byte, most significant bit on top.
    localparam int PIX_PER_BYTE = 8;

    // Default screen geometry.
    localparam int SCREEN_WIDTH_DEF = 256;
    localparam int SCREEN_PAGES_DEF = 20;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch an accepted item and set up the walk
        logic clr_wr;   // write zero at the clear counter and advance it
        logic rd_pix;   // read the byte under the cursor
        logic wr_pix;   // write the read byte with the cursor pixel set
        logic step;     // advance the walk by one Bresenham step
        logic rd_host;  // read the host addressed byte
        logic wr_host;  // write the host byte
        logic res_load; // load the result register
        logic res_mem;  // result comes from the read data, else zero
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;    // cursor sits on the end point
        logic on_screen; // cursor pixel lies on screen
        logic clr_last;  // clear counter is at the last byte
    } t_status;

endpackage

// ----- rtl/lrpf_ctrl.sv -----
// Controller state machine of the line rasterizer: sequences the clear pass,
// the line walk, host byte access and the result register. Uses lrpf_pkg.
module lrpf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [lrpf_pkg::MODE_W-1:0]   i_mode,
    input  logic                          i_out_stall,
    input  lrpf_pkg::t_status             i_status,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output lrpf_pkg::t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PLOT_RD,
        S_PLOT_WR,
        S_HOST_RD,
        S_HOST_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_res_mem, n_res_mem;
    logic   out_free;

    // The result register is free when empty or being taken this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_res_mem   = r_res_mem;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.res_mem = r_res_mem;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_res_mem  = 1'b0;
                    unique case (i_mode)
                        lrpf_pkg::MODE_DRAW:  n_state = S_PLOT_RD;
                        lrpf_pkg::MODE_READ: begin
                            n_state   = S_HOST_RD;
                            n_res_mem = 1'b1;
                        end
                        lrpf_pkg::MODE_WRITE: n_state = S_HOST_WR;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_PLOT_RD: begin
                if (i_status.on_screen) begin
                    o_cmd.rd_pix = 1'b1;
                    n_state      = S_PLOT_WR;
                end else if (i_status.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_PLOT_WR: begin
                o_cmd.wr_pix = 1'b1;
                if (i_status.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_PLOT_RD;
                end
            end
            S_HOST_RD: begin
                o_cmd.rd_host = 1'b1;
                n_state       = S_DONE;
            end
            S_HOST_WR: begin
                o_cmd.wr_host = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_res_mem   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_res_mem   <= n_res_mem;
        end
    end

endmodule

// ----- rtl/lrpf_dpath.sv -----
// Datapath of the line rasterizer: framebuffer memory, Bresenham walk
// registers, clear counter and result register. Uses lrpf_pkg.
module lrpf_dpath #(
    parameter int SCREEN_WIDTH = lrpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_PAGES = lrpf_pkg::SCREEN_PAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lrpf_pkg::t_cmd                       i_cmd,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_end_y,
    input  logic [lrpf_pkg::ADDR_W-1:0]          i_byte_address,
    input  logic [lrpf_pkg::BYTE_W-1:0]          i_write_byte,
    output lrpf_pkg::t_status                    o_status,
    output logic [lrpf_pkg::BYTE_W-1:0]          o_read_byte
);

    localparam int CW       = lrpf_pkg::COORD_W;
    localparam int EW       = lrpf_pkg::ERR_W;
    localparam int BW       = lrpf_pkg::BYTE_W;
    localparam int FB_BYTES = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int IDX_W    = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int HEIGHT   = SCREEN_PAGES * lrpf_pkg::PIX_PER_BYTE;
    localparam int PROD_W   = 17;

    // Framebuffer and its read register.
    logic [BW-1:0]    r_mem [FB_BYTES];
    logic [BW-1:0]    r_rd_data;

    // Walk registers.
    logic signed [CW-1:0] r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic signed [CW:0]   r_dx, r_dy;
    logic                 r_sx_pos, r_sy_pos;
    logic signed [EW-1:0] r_err;

    // Host access and clear registers.
    logic [IDX_W-1:0]     r_host_idx;
    logic [BW-1:0]        r_host_data;
    logic                 r_host_ok;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [BW-1:0]        r_result;

    // Setup terms.
    logic signed [CW:0]   diff_x, diff_y, abs_x, abs_y;
    logic signed [EW-1:0] err_init;

    // Step terms.
    logic signed [EW:0]   e2, dx_e, dy_e, err_sum;
    logic                 c_x, c_y;

    // Pixel address terms.
    logic [PROD_W-1:0]    pix_prod;
    logic [IDX_W-1:0]     pix_idx;
    logic [BW-1:0]        pix_mask;

    // Memory port selection.
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_wa, mem_ra;
    logic [BW-1:0]        mem_wd;

    // Line setup from the incoming end points.
    always_comb begin
        diff_x   = $signed({i_end_x[CW-1], i_end_x}) - $signed({i_start_x[CW-1], i_start_x});
        diff_y   = $signed({i_end_y[CW-1], i_end_y}) - $signed({i_start_y[CW-1], i_start_y});
        abs_x    = diff_x[CW] ? -diff_x : diff_x;
        abs_y    = diff_y[CW] ? -diff_y : diff_y;
        err_init = $signed({abs_x[CW], abs_x}) - $signed({abs_y[CW], abs_y});
    end

    // One Bresenham step: both axes may move in the same step.
    always_comb begin
        e2      = $signed({r_err, 1'b0});
        dx_e    = $signed({{(EW-CW){r_dx[CW]}}, r_dx});
        dy_e    = $signed({{(EW-CW){r_dy[CW]}}, r_dy});
        c_x     = (e2 >= dy_e);
        c_y     = (e2 <= dx_e);
        err_sum = $signed({r_err[EW-1], r_err}) + (c_x ? dy_e : '0) + (c_y ? dx_e : '0);
    end

    // Byte index and bit mask of the cursor pixel.
    always_comb begin
        pix_prod = PROD_W'(r_cur_y[CW-2:3]) * PROD_W'(SCREEN_WIDTH)
                 + PROD_W'(r_cur_x[CW-2:0]);
        pix_idx  = pix_prod[IDX_W-1:0];
        pix_mask = BW'(8'h80) >> r_cur_y[2:0];
    end

    // Status toward the controller.
    assign o_status.at_end    = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);
    assign o_status.on_screen = !r_cur_x[CW-1] && ({1'b0, r_cur_x[CW-2:0]} < CW'(SCREEN_WIDTH))
                             && !r_cur_y[CW-1] && ({1'b0, r_cur_y[CW-2:0]} < CW'(HEIGHT));
    assign o_status.clr_last  = (r_clr_idx == IDX_W'(FB_BYTES - 1));
    assign o_read_byte        = r_result;

    // Memory port muxing: clear, pixel update or host access.
    always_comb begin
        mem_we = i_cmd.clr_wr || i_cmd.wr_pix || (i_cmd.wr_host && r_host_ok);
        mem_re = i_cmd.rd_pix || (i_cmd.rd_host && r_host_ok);
        mem_ra = i_cmd.rd_pix ? pix_idx : r_host_idx;
        if (i_cmd.clr_wr) begin
            mem_wa = r_clr_idx;
            mem_wd = '0;
        end else if (i_cmd.wr_pix) begin
            mem_wa = pix_idx;
            mem_wd = r_rd_data | pix_mask;
        end else begin
            mem_wa = r_host_idx;
            mem_wd = r_host_data;
        end
    end

    // Framebuffer write and registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    // Clear counter, swept once after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr && !o_status.clr_last) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // Walk state and item latch.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_err   <= '0;
        end else if (i_cmd.load) begin
            r_cur_x <= i_start_x;
            r_cur_y <= i_start_y;
            r_err   <= err_init;
        end else if (i_cmd.step) begin
            r_err <= err_sum[EW-1:0];
            if (c_x) begin
                r_cur_x <= r_sx_pos ? r_cur_x + CW'(1) : r_cur_x - CW'(1);
            end
            if (c_y) begin
                r_cur_y <= r_sy_pos ? r_cur_y + CW'(1) : r_cur_y - CW'(1);
            end
        end
    end

    // Item payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_end_x     <= i_end_x;
            r_end_y     <= i_end_y;
            r_dx        <= abs_x;
            r_dy        <= -abs_y;
            r_sx_pos    <= (i_start_x < i_end_x);
            r_sy_pos    <= (i_start_y < i_end_y);
            r_host_idx  <= i_byte_address[IDX_W-1:0];
            r_host_data <= i_write_byte;
            r_host_ok   <= ({1'b0, i_byte_address} < (lrpf_pkg::ADDR_W + 1)'(FB_BYTES));
        end
    end

    // Result register: read data in read mode when the address is valid.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result <= (i_cmd.res_mem && r_host_ok) ? r_rd_data : '0;
        end
    end

endmodule

// ----- rtl/line_rasterizer_page_framebuffer_core.sv -----
// Top level of the line rasterizer over a paged 1-bit-per-pixel framebuffer.
// Instantiates lrpf_ctrl and lrpf_dpath; uses lrpf_pkg.
//
// Input channel (i_in_valid / o_in_stall) carries one item: a line to draw,
// a framebuffer byte to read, or a byte to write. Output channel
// (o_out_valid / i_out_stall) returns exactly one byte per item: the read
// byte in read mode for an in-range address, zero otherwise.
//
// A read or write passes through the load, a host access state and the done
// state before the result register is loaded. Each on-screen pixel of a line
// takes a read state and a write state, the read-modify-write of its byte
// through the single framebuffer; a clipped pixel takes only a step.
// One item is in work at a time; the next is taken while the previous
// result waits in the output register.
//
// After reset the framebuffer is cleared one byte per cycle, all of its
// SCREEN_WIDTH * SCREEN_PAGES bytes (5120 by default); o_in_stall stays
// high until the last byte is cleared. If the receiver stalls, the result
// is held and a finished item waits until the output register is free.
module line_rasterizer_page_framebuffer_core #(
    parameter int SCREEN_WIDTH = lrpf_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_PAGES = lrpf_pkg::SCREEN_PAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lrpf_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [lrpf_pkg::COORD_W-1:0]  i_end_y,
    input  logic [lrpf_pkg::ADDR_W-1:0]          i_byte_address,
    input  logic [lrpf_pkg::BYTE_W-1:0]          i_write_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [lrpf_pkg::BYTE_W-1:0]          o_read_byte
);

    lrpf_pkg::t_cmd    cmd;
    lrpf_pkg::t_status status;

    // Controller.
    lrpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Datapath with the framebuffer.
    lrpf_dpath #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_PAGES (SCREEN_PAGES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_byte_address (i_byte_address),
        .i_write_byte   (i_write_byte),
        .o_status       (status),
        .o_read_byte    (o_read_byte)
    );

    // The block is busy in the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // Loading the result register always presents a result.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |=> o_out_valid)
        else $error("result loaded but not presented");

    // A pixel write always follows the read of the same byte.
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_pix |-> $past(cmd.rd_pix))
        else $error("pixel write without a preceding read");

    // The walk never steps past its end point.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !status.at_end)
        else $error("walk stepped beyond the end point");

endmodule
